/* rtl/hdm_pkg.sv */
// hdm_pkg: widths, types and constants shared by the holonomic drive mixer
// used by hdm_div_pipe and holonomic_drive_mixer; no dependencies
package hdm_pkg;

  localparam int STICK_W    = 8;   // signed stick percentage
  localparam int SPEED_W    = 16;  // signed wheel command
  localparam int NUM_WHEELS = 4;
  localparam int DEN_W      = 9;   // |forward| + |strafe|, up to 256
  localparam int MX_W       = 8;   // larger stick magnitude, up to 128
  localparam int MIX_W      = 10;  // forward +- strafe
  localparam int WHEEL_W    = 18;  // wheel numerator over the common denominator
  localparam int MAG_W      = 17;  // wheel magnitude and peak, up to 65536
  localparam int MAG100_W   = 23;  // magnitude times 100
  localparam int HEAD_W     = 7;   // bits of the percent scale, 100 < 2**7
  localparam int REM_W      = 17;  // divider remainder, below the peak
  localparam int PCT        = 100;

  // wheel order in the result word, lowest first
  localparam int WH_FL = 0;
  localparam int WH_BL = 1;
  localparam int WH_FR = 2;
  localparam int WH_BR = 3;

  typedef logic signed [STICK_W-1:0] stick_t;
  typedef logic signed [MIX_W-1:0]   mix_t;
  typedef logic signed [WHEEL_W-1:0] wheel_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [MAG100_W-1:0]       mag100_t;
  typedef logic [REM_W-1:0]          rem_t;

  // control that rides alongside the divider lanes
  typedef struct packed {
    logic                  valid;
    logic [NUM_WHEELS-1:0] neg;
  } div_tag_t;

endpackage

/* rtl/hdm_div_pipe.sv */
// hdm_div_pipe: four-lane restoring divider, one quotient bit per register stage
// quotient = (mag100 << frac bits) / peak; depends on hdm_pkg
module hdm_div_pipe #(
  parameter int QUOT_W = 15
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             en,
  input  hdm_pkg::div_tag_t                                in_tag,
  input  hdm_pkg::mag100_t [hdm_pkg::NUM_WHEELS-1:0]       in_mag100,
  input  hdm_pkg::mag_t                                    in_peak,
  output hdm_pkg::div_tag_t                                out_tag,
  output logic [hdm_pkg::NUM_WHEELS-1:0][QUOT_W-1:0]       out_quot
);

  localparam int NW      = hdm_pkg::NUM_WHEELS;
  localparam int HW      = hdm_pkg::HEAD_W;
  localparam int REM_W_P = hdm_pkg::REM_W;

  hdm_pkg::rem_t        rem_r  [QUOT_W][NW];
  logic [QUOT_W-1:0]    quot_r [QUOT_W][NW];
  logic [HW-1:0]        feed_r [QUOT_W][NW];
  hdm_pkg::mag_t        peak_r [QUOT_W];
  hdm_pkg::div_tag_t    tag_r  [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    hdm_pkg::mag_t     src_peak;
    hdm_pkg::div_tag_t src_tag;

    if (k == 0) begin : g_first
      assign src_peak = in_peak;
      assign src_tag  = in_tag;
    end else begin : g_next
      assign src_peak = peak_r[k-1];
      assign src_tag  = tag_r[k-1];
    end

    for (genvar l = 0; l < NW; l++) begin : g_lane
      hdm_pkg::rem_t     src_rem;
      logic [QUOT_W-1:0] src_quot;
      logic [HW-1:0]     src_feed;
      logic [REM_W_P:0]  trial;
      logic [REM_W_P:0]  diff;
      logic              ge;

      if (k == 0) begin : g_first
        // top bits of the dividend are already below the peak
        assign src_rem  = hdm_pkg::REM_W'({1'b0, in_mag100[l][hdm_pkg::MAG100_W-1:HW]});
        assign src_quot = '0;
        assign src_feed = in_mag100[l][HW-1:0];
      end else begin : g_next
        assign src_rem  = rem_r[k-1][l];
        assign src_quot = quot_r[k-1][l];
        assign src_feed = feed_r[k-1][l];
      end

      always_comb begin
        trial = {src_rem, src_feed[HW-1]};
        diff  = trial - {1'b0, src_peak};
        ge    = (trial >= {1'b0, src_peak});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l]  <= ge ? diff[hdm_pkg::REM_W-1:0] : trial[hdm_pkg::REM_W-1:0];
          quot_r[k][l] <= {src_quot[QUOT_W-2:0], ge};
          feed_r[k][l] <= {src_feed[HW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        peak_r[k] <= src_peak;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else if (en) begin
        tag_r[k] <= src_tag;
      end
    end
  end

  assign out_tag = tag_r[QUOT_W-1];

  for (genvar l = 0; l < NW; l++) begin : g_out
    assign out_quot[l] = quot_r[QUOT_W-1][l];
  end

endmodule

/* rtl/holonomic_drive_mixer.sv */
// holonomic_drive_mixer: stick to wheel mixing with desaturation, top level
// depends on hdm_pkg and hdm_div_pipe
//
// Takes one transfer of three signed stick percentages and returns one transfer of
// four signed wheel commands in percent with OUT_FRAC_BITS fraction bits, truncated
// toward zero. The block is a fully pipelined datapath: it accepts a new item every
// cycle while the output is not stalled. Five stages do the mixing, the products, the
// wheel sums, the magnitudes and the peak; then a restoring divider spends one stage
// per quotient bit (7 + OUT_FRAC_BITS stages, four lanes side by side), and an output
// register applies the sign. When the output register is full and not taken the whole
// pipeline holds; in_tready is low exactly then.
module holonomic_drive_mixer #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // forward_stick, strafe_stick, turn_stick
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // fl, bl, fr, br wheel speed
);

  localparam int NW     = hdm_pkg::NUM_WHEELS;
  localparam int SW     = hdm_pkg::SPEED_W;
  localparam int QUOT_W = hdm_pkg::HEAD_W + OUT_FRAC_BITS;
  localparam int XW     = (QUOT_W > SW) ? QUOT_W : SW;
  localparam logic [QUOT_W-1:0] QUOT_MAX = QUOT_W'(hdm_pkg::PCT) << OUT_FRAC_BITS;

  logic en;
  logic out_valid_r;
  logic [63:0] out_data_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // stage 1: translation mix and common denominator
  hdm_pkg::stick_t f_in, s_in, t_in;
  logic signed [hdm_pkg::STICK_W:0] fx, sx, fa, sa;
  logic [hdm_pkg::MX_W-1:0]  af, as_;
  logic [hdm_pkg::DEN_W-1:0] sum;
  hdm_pkg::mix_t pa_nxt, pb_nxt;
  logic [hdm_pkg::DEN_W-1:0] den_nxt;
  logic [hdm_pkg::MX_W-1:0]  mx_nxt;

  always_comb begin
    f_in    = in_tdata[7:0];
    s_in    = in_tdata[15:8];
    t_in    = in_tdata[23:16];
    fx      = {f_in[7], f_in};
    sx      = {s_in[7], s_in};
    fa      = fx[hdm_pkg::STICK_W] ? -fx : fx;
    sa      = sx[hdm_pkg::STICK_W] ? -sx : sx;
    af      = fa[hdm_pkg::MX_W-1:0];
    as_     = sa[hdm_pkg::MX_W-1:0];
    sum     = {1'b0, af} + {1'b0, as_};
    // both sticks centered: both mixes are zero, so scaling by mx changes nothing
    den_nxt = (sum == '0) ? hdm_pkg::DEN_W'(1) : sum;
    mx_nxt  = (af > as_) ? af : as_;
    pa_nxt  = {fx[hdm_pkg::STICK_W], fx} + {sx[hdm_pkg::STICK_W], sx};
    pb_nxt  = {fx[hdm_pkg::STICK_W], fx} - {sx[hdm_pkg::STICK_W], sx};
  end

  hdm_pkg::mix_t pa_r, pb_r;
  hdm_pkg::stick_t t_r;
  logic [hdm_pkg::DEN_W-1:0] den_r;
  logic [hdm_pkg::MX_W-1:0]  mx_r;
  logic v1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      t_r   <= t_in;
      den_r <= den_nxt;
      mx_r  <= mx_nxt;
    end
  end

  // stage 2: scaled mixes and turn over the denominator
  logic signed [hdm_pkg::WHEEL_W:0] pam_full, pbm_full, td_full;
  hdm_pkg::wheel_t pam_r, pbm_r, td_r;
  logic [hdm_pkg::DEN_W-1:0] den2_r;
  logic v2_r;

  always_comb begin
    pam_full = pa_r * $signed({1'b0, mx_r});
    pbm_full = pb_r * $signed({1'b0, mx_r});
    td_full  = t_r * $signed({1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pam_r  <= pam_full[hdm_pkg::WHEEL_W-1:0];
      pbm_r  <= pbm_full[hdm_pkg::WHEEL_W-1:0];
      td_r   <= td_full[hdm_pkg::WHEEL_W-1:0];
      den2_r <= den_r;
    end
  end

  // stage 3: wheel numerators and the 100 percent floor of the peak
  hdm_pkg::wheel_t w_r [NW];
  hdm_pkg::mag_t   p100_r;
  logic [hdm_pkg::MAG_W+hdm_pkg::DEN_W-1:0] p100_full;
  logic v3_r;

  assign p100_full = den2_r * hdm_pkg::MAG_W'(hdm_pkg::PCT);

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[hdm_pkg::WH_FL] <= pam_r + td_r;
      w_r[hdm_pkg::WH_BL] <= pbm_r + td_r;
      w_r[hdm_pkg::WH_FR] <= pbm_r - td_r;
      w_r[hdm_pkg::WH_BR] <= pam_r - td_r;
      p100_r              <= p100_full[hdm_pkg::MAG_W-1:0];
    end
  end

  // stage 4: magnitudes and signs
  hdm_pkg::mag_t mag_r [NW];
  logic [NW-1:0] neg4_r;
  hdm_pkg::mag_t p100_4_r;
  logic v4_r;

  for (genvar l = 0; l < NW; l++) begin : g_mag
    hdm_pkg::wheel_t wa;
    assign wa = w_r[l][hdm_pkg::WHEEL_W-1] ? -w_r[l] : w_r[l];
    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[l]  <= wa[hdm_pkg::MAG_W-1:0];
        neg4_r[l] <= w_r[l][hdm_pkg::WHEEL_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p100_4_r <= p100_r;
    end
  end

  // stage 5: peak and dividend head
  hdm_pkg::mag_t pk_a, pk_b, peak_nxt;
  hdm_pkg::mag_t peak_r;
  hdm_pkg::mag100_t [NW-1:0] mag100_r;
  hdm_pkg::div_tag_t tag5_r;

  always_comb begin
    pk_a     = (mag_r[hdm_pkg::WH_FL] > mag_r[hdm_pkg::WH_BL]) ?
               mag_r[hdm_pkg::WH_FL] : mag_r[hdm_pkg::WH_BL];
    pk_b     = (mag_r[hdm_pkg::WH_FR] > mag_r[hdm_pkg::WH_BR]) ?
               mag_r[hdm_pkg::WH_FR] : mag_r[hdm_pkg::WH_BR];
    peak_nxt = (pk_a > pk_b) ? pk_a : pk_b;
    if (p100_4_r > peak_nxt) begin
      peak_nxt = p100_4_r;
    end
  end

  for (genvar l = 0; l < NW; l++) begin : g_m100
    logic [hdm_pkg::MAG_W+hdm_pkg::HEAD_W-1:0] m100_full;
    assign m100_full = mag_r[l] * hdm_pkg::HEAD_W'(hdm_pkg::PCT);
    always_ff @(posedge clk) begin
      if (en) begin
        mag100_r[l] <= m100_full[hdm_pkg::MAG100_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      peak_r <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      tag5_r <= '0;
    end else if (en) begin
      v1_r   <= in_tvalid;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      tag5_r <= '{valid: v4_r, neg: neg4_r};
    end
  end

  // divider stages
  hdm_pkg::div_tag_t div_tag;
  logic [NW-1:0][QUOT_W-1:0] div_quot;

  hdm_div_pipe #(
    .QUOT_W(QUOT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_tag   (tag5_r),
    .in_mag100(mag100_r),
    .in_peak  (peak_r),
    .out_tag  (div_tag),
    .out_quot (div_quot)
  );

  // output register: apply the sign, keep the low field bits
  logic [63:0] out_data_nxt;

  for (genvar l = 0; l < NW; l++) begin : g_sign
    logic [XW-1:0] qx, qs;
    assign qx = XW'(div_quot[l]);
    assign qs = div_tag.neg[l] ? -qx : qx;
    assign out_data_nxt[l*SW +: SW] = qs[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_tag.valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // the peak never falls below 100 percent of the denominator, so it is never zero
  a_peak_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    tag5_r.valid |-> (peak_r != '0))
    else $error("peak is zero on a valid item");

  // desaturation bounds every quotient to 100 percent
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_tag.valid |-> (div_quot[0] <= QUOT_MAX) && (div_quot[1] <= QUOT_MAX) &&
                      (div_quot[2] <= QUOT_MAX) && (div_quot[3] <= QUOT_MAX))
    else $error("wheel quotient above full scale");

  // an item leaving the divider while the pipe moves lands in the output register
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (div_tag.valid && en) |=> out_tvalid)
    else $error("result lost at the output register");

endmodule
